@@ sv/hmm_viterbi_online_decoder_core_defines.svh @@
// Assertion macros for the online HMM Viterbi decoder.
// Depends on nothing; taken in by the top level with `include.
`ifndef HMM_VITERBI_ONLINE_DECODER_CORE_DEFINES_SVH
`define HMM_VITERBI_ONLINE_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define HVD_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("hvd assertion failed");
// Next-cycle implication.
`define HVD_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hvd assertion failed");
`else
`define HVD_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define HVD_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

@@ sv/hvd_pkg.sv @@
// Shared types, codes and default constants of the HMM Viterbi decoder.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hvd_pkg;
  localparam int DEF_NUM_STATES  = 8;
  localparam int DEF_MAX_STEPS   = 1024;
  localparam int DEF_METRIC_WIDTH = 32;
  localparam logic signed [15:0] LOG_NEG_INF = 16'sh8000;

  typedef enum logic [2:0] {
    FN_LD_TRANS = 3'd0,
    FN_LD_START = 3'd1,
    FN_LD_FINAL = 3'd2,
    FN_LD_LABEL = 3'd3,
    FN_EMIT     = 3'd4,
    FN_STOP     = 3'd5,
    FN_TRACE    = 3'd6,
    FN_CLEAR    = 3'd7
  } func_e_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOSTEPS = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_CLR, S_RD, S_ADD, S_CMP, S_FIN, S_TBRD, S_TBOUT
  } fsm_t;

  typedef enum logic [1:0] {
    LM_FIRST, LM_EMIT, LM_STOP, LM_BEST
  } loop_mode_t;

  typedef struct packed {
    func_e_t            func;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] log_value;
    logic               step_last;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] state_label;
    logic [2:0]         best_state;
    logic               trace_done;
  } out_t;

  typedef struct packed {
    logic               en;
    func_e_t            sel;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] data;
  } tbl_wr_t;
endpackage
`default_nettype wire

@@ sv/hmm_viterbi_online_decoder_core.sv @@
// Online HMM Viterbi decoder, top level; depends on hvd_pkg and the three sub-blocks.
// Steps from start beat to done beat: loads, clear and refused requests are settled at dispatch;
//   emission clears the new metric bank if it opens a step, then scans the n states in use
//   (the first step reads only the start score) and writes back; stop scans the n states;
//   traceback reads one back pointer, after a best-state scan when it starts; one item at a time.
// Reset (rst, sync, high) empties the trellis; done cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "hmm_viterbi_online_decoder_core_defines.svh"
module hmm_viterbi_online_decoder_core #(
  parameter int NUM_STATES   = hvd_pkg::DEF_NUM_STATES,
  parameter int MAX_STEPS    = hvd_pkg::DEF_MAX_STEPS,
  parameter int METRIC_WIDTH = hvd_pkg::DEF_METRIC_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire hvd_pkg::in_t  item,
  output logic               done,
  output hvd_pkg::out_t      result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [3:0]    cfg_data
);
  localparam int SW = $clog2(NUM_STATES);
  localparam int CW = $clog2(MAX_STEPS);

  logic [3:0] states_in_use;

  hvd_pkg::tbl_wr_t   tbl_wr;
  logic [2*SW-1:0]    trans_raddr;
  logic [SW-1:0]      vec_raddr;
  logic signed [15:0] trans_rdata, start_rdata, final_rdata, label_rdata;
  logic               pm_we, bp_we;
  logic [SW:0]        pm_waddr, pm_raddr;
  logic signed [METRIC_WIDTH-1:0] pm_wdata, pm_rdata;
  logic [CW+SW-1:0]   bp_waddr, bp_raddr;
  logic [SW-1:0]      bp_wdata, bp_rdata;
  logic               fields_zero;

  // Config beats land whenever offered; the host writes only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      states_in_use <= 4'd5;
    end else if (cfg_valid && cfg_ready) begin
      states_in_use <= cfg_data;
    end
  end

  // Tables loaded by the host.
  hvd_score_store #(.NUM_STATES(NUM_STATES)) u_scores (
    .clk, .wr(tbl_wr), .trans_raddr, .vec_raddr,
    .trans_rdata, .start_rdata, .final_rdata, .label_rdata
  );

  // Path metrics (two banks, ping-pong per step) and back pointers.
  hvd_trellis_store #(
    .NUM_STATES(NUM_STATES), .MAX_STEPS(MAX_STEPS), .METRIC_WIDTH(METRIC_WIDTH)
  ) u_trellis (
    .clk, .pm_we, .pm_waddr, .pm_wdata, .pm_raddr, .pm_rdata,
    .bp_we, .bp_waddr, .bp_wdata, .bp_raddr, .bp_rdata
  );

  // Sequencer: works one state at a time; metric updates are read, then modify, then
  // write back, so a read never overtakes a pending write to the same entry.
  hvd_ctrl #(
    .NUM_STATES(NUM_STATES), .MAX_STEPS(MAX_STEPS), .METRIC_WIDTH(METRIC_WIDTH)
  ) u_ctrl (
    .clk, .rst, .start, .busy, .item, .states_in_use, .done, .result,
    .tbl_wr, .trans_raddr, .vec_raddr,
    .trans_rdata, .start_rdata, .final_rdata, .label_rdata,
    .pm_we, .pm_waddr, .pm_wdata, .pm_raddr, .pm_rdata,
    .bp_we, .bp_waddr, .bp_wdata, .bp_raddr, .bp_rdata
  );

  assign fields_zero = result.state_label == 16'sd0 && result.best_state == 3'd0 &&
                       !result.trace_done;

  // A result beat is only issued once the sequencer has gone back to idle.
  `HVD_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  // An accepted request always holds the block busy in the next cycle.
  `HVD_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  // Refused requests carry nothing but their status.
  `HVD_ASSERT_IMP(a_err_clean, clk, rst, done && result.status != hvd_pkg::ST_OK, fields_zero)
endmodule
`default_nettype wire

@@ sv/hvd_score_store.sv @@
// Score and label tables: transitions, start, final and labels, registered reads.
// Depends on hvd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hvd_score_store #(
  parameter int NUM_STATES = hvd_pkg::DEF_NUM_STATES
) (
  input  wire logic                 clk,
  input  wire hvd_pkg::tbl_wr_t     wr,
  input  wire logic [2*$clog2(NUM_STATES)-1:0] trans_raddr,
  input  wire logic [$clog2(NUM_STATES)-1:0]   vec_raddr,
  output logic signed [15:0]        trans_rdata,
  output logic signed [15:0]        start_rdata,
  output logic signed [15:0]        final_rdata,
  output logic signed [15:0]        label_rdata
);
  localparam int SW = $clog2(NUM_STATES);

  logic signed [15:0] trans_mem [1 << (2*SW)];
  logic signed [15:0] start_mem [1 << SW];
  logic signed [15:0] final_mem [1 << SW];
  logic signed [15:0] label_mem [1 << SW];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      unique case (wr.sel)
        hvd_pkg::FN_LD_TRANS: trans_mem[{SW'(wr.row), SW'(wr.col)}] <= wr.data;
        hvd_pkg::FN_LD_START: start_mem[SW'(wr.row)] <= wr.data;
        hvd_pkg::FN_LD_FINAL: final_mem[SW'(wr.row)] <= wr.data;
        hvd_pkg::FN_LD_LABEL: label_mem[SW'(wr.row)] <= wr.data;
        default: ;
      endcase
    end
    trans_rdata <= trans_mem[trans_raddr];
    start_rdata <= start_mem[vec_raddr];
    final_rdata <= final_mem[vec_raddr];
    label_rdata <= label_mem[vec_raddr];
  end
endmodule
`default_nettype wire

@@ sv/hvd_trellis_store.sv @@
// Path metric banks and back pointer memory, one write and one read port each.
// Depends on hvd_pkg for parameter defaults.
`timescale 1ns / 1ps
`default_nettype none
module hvd_trellis_store #(
  parameter int NUM_STATES   = hvd_pkg::DEF_NUM_STATES,
  parameter int MAX_STEPS    = hvd_pkg::DEF_MAX_STEPS,
  parameter int METRIC_WIDTH = hvd_pkg::DEF_METRIC_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  pm_we,
  input  wire logic [$clog2(NUM_STATES):0]           pm_waddr,
  input  wire logic signed [METRIC_WIDTH-1:0]        pm_wdata,
  input  wire logic [$clog2(NUM_STATES):0]           pm_raddr,
  output logic signed [METRIC_WIDTH-1:0]             pm_rdata,
  input  wire logic                                  bp_we,
  input  wire logic [$clog2(MAX_STEPS)+$clog2(NUM_STATES)-1:0] bp_waddr,
  input  wire logic [$clog2(NUM_STATES)-1:0]         bp_wdata,
  input  wire logic [$clog2(MAX_STEPS)+$clog2(NUM_STATES)-1:0] bp_raddr,
  output logic [$clog2(NUM_STATES)-1:0]              bp_rdata
);
  localparam int SW = $clog2(NUM_STATES);
  localparam int CW = $clog2(MAX_STEPS);

  logic signed [METRIC_WIDTH-1:0] pm_mem [2 << SW];
  logic [SW-1:0]                  bp_mem [1 << (CW + SW)];

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
    pm_rdata <= pm_mem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= bp_wdata;
    end
    bp_rdata <= bp_mem[bp_raddr];
  end
endmodule
`default_nettype wire

@@ sv/hvd_ctrl.sv @@
// Sequencer of the decoder: request dispatch, predecessor scan, traceback.
// Depends on hvd_pkg; drives hvd_score_store and hvd_trellis_store.
`timescale 1ns / 1ps
`default_nettype none
module hvd_ctrl #(
  parameter int NUM_STATES   = hvd_pkg::DEF_NUM_STATES,
  parameter int MAX_STEPS    = hvd_pkg::DEF_MAX_STEPS,
  parameter int METRIC_WIDTH = hvd_pkg::DEF_METRIC_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire hvd_pkg::in_t                   item,
  input  wire logic [3:0]                     states_in_use,
  output logic                                done,
  output hvd_pkg::out_t                       result,
  output hvd_pkg::tbl_wr_t                    tbl_wr,
  output logic [2*$clog2(NUM_STATES)-1:0]     trans_raddr,
  output logic [$clog2(NUM_STATES)-1:0]       vec_raddr,
  input  wire logic signed [15:0]             trans_rdata,
  input  wire logic signed [15:0]             start_rdata,
  input  wire logic signed [15:0]             final_rdata,
  input  wire logic signed [15:0]             label_rdata,
  output logic                                pm_we,
  output logic [$clog2(NUM_STATES):0]         pm_waddr,
  output logic signed [METRIC_WIDTH-1:0]      pm_wdata,
  output logic [$clog2(NUM_STATES):0]         pm_raddr,
  input  wire logic signed [METRIC_WIDTH-1:0] pm_rdata,
  output logic                                bp_we,
  output logic [$clog2(MAX_STEPS)+$clog2(NUM_STATES)-1:0] bp_waddr,
  output logic [$clog2(NUM_STATES)-1:0]       bp_wdata,
  output logic [$clog2(MAX_STEPS)+$clog2(NUM_STATES)-1:0] bp_raddr,
  input  wire logic [$clog2(NUM_STATES)-1:0]  bp_rdata
);
  localparam int SW  = $clog2(NUM_STATES);
  localparam int NW  = $clog2(NUM_STATES + 1);
  localparam int CW  = $clog2(MAX_STEPS);
  localparam int SCW = $clog2(MAX_STEPS + 1);
  localparam int MW  = METRIC_WIDTH;
  localparam logic signed [MW-1:0] MET_MIN = {1'b1, {(MW-1){1'b0}}};
  localparam logic signed [MW-1:0] MET_MAX = {1'b0, {(MW-1){1'b1}}};

  // Saturating metric add; the minimum metric and a LOG_NEG_INF log value are absorbing.
  function automatic logic signed [MW-1:0] met_add(input logic signed [MW-1:0] m,
                                                   input logic signed [15:0] l);
    logic signed [MW:0] s;
    s = (MW+1)'(m) + (MW+1)'(l);
    if (m == MET_MIN || l == hvd_pkg::LOG_NEG_INF) return MET_MIN;
    if (s[MW] != s[MW-1]) return s[MW] ? MET_MIN : MET_MAX;
    return s[MW-1:0];
  endfunction

  hvd_pkg::fsm_t       st, st_next;
  hvd_pkg::loop_mode_t mode;
  hvd_pkg::in_t        req;
  logic [SW-1:0]       sidx;
  logic                lbank, wbank;
  logic [CW-1:0]       cur, cursor;
  logic [SCW-1:0]      step_count;
  logic                step_open, trace_active;
  logic [SW-1:0]       traced, best;
  logic signed [MW-1:0] bm, cand;

  logic [NW-1:0]       n_used;
  logic [SW-1:0]       row_s;
  logic                row_bad_ld, col_bad_ld, row_bad_em, s_last, upd;
  logic [SW-1:0]       best_now;
  logic [CW-1:0]       last_step;
  logic                fin_en;
  hvd_pkg::out_t       fin_res;

  always_comb begin
    if (states_in_use == 4'd0) n_used = NW'(1);
    else if (32'(states_in_use) > NUM_STATES) n_used = NW'(NUM_STATES);
    else n_used = NW'(states_in_use);
  end

  assign row_s      = SW'(req.row_index);
  assign row_bad_ld = 32'(req.row_index) >= NUM_STATES;
  assign col_bad_ld = 32'(req.col_index) >= NUM_STATES;
  assign row_bad_em = 32'(req.row_index) >= 32'(n_used);
  assign s_last     = NW'(sidx) == n_used - NW'(1);
  assign upd        = (sidx == '0) || (cand > bm);
  assign best_now   = upd ? sidx : best;
  assign last_step  = CW'(step_count - SCW'(1));
  assign busy       = st != hvd_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) st <= hvd_pkg::S_IDLE;
    else     st <= st_next;
  end

  always_comb begin
    st_next     = st;
    fin_en      = 1'b0;
    fin_res     = '0;
    tbl_wr      = '0;
    trans_raddr = {sidx, row_s};
    vec_raddr   = (mode == hvd_pkg::LM_FIRST) ? row_s : sidx;
    pm_we       = 1'b0;
    pm_waddr    = {wbank, sidx};
    pm_wdata    = cand;
    pm_raddr    = {lbank, sidx};
    bp_we       = 1'b0;
    bp_waddr    = {cur, sidx};
    bp_wdata    = '0;
    bp_raddr    = {cursor, traced};
    unique case (st)
      hvd_pkg::S_IDLE: begin
        if (start) st_next = hvd_pkg::S_DISP;
      end
      hvd_pkg::S_DISP: begin
        st_next = hvd_pkg::S_IDLE;
        fin_en  = 1'b1;
        unique case (req.func)
          hvd_pkg::FN_LD_TRANS: begin
            if (row_bad_ld || col_bad_ld) fin_res.status = hvd_pkg::ST_BAD;
            else tbl_wr = '{1'b1, req.func, req.row_index, req.col_index, req.log_value};
          end
          hvd_pkg::FN_LD_START, hvd_pkg::FN_LD_FINAL, hvd_pkg::FN_LD_LABEL: begin
            if (row_bad_ld) fin_res.status = hvd_pkg::ST_BAD;
            else tbl_wr = '{1'b1, req.func, req.row_index, req.col_index, req.log_value};
          end
          hvd_pkg::FN_EMIT: begin
            if (row_bad_em) fin_res.status = hvd_pkg::ST_BAD;
            else if (!step_open && 32'(step_count) >= MAX_STEPS)
              fin_res.status = hvd_pkg::ST_FULL;
            else begin
              fin_en  = 1'b0;
              st_next = step_open ? hvd_pkg::S_RD : hvd_pkg::S_CLR;
            end
          end
          hvd_pkg::FN_STOP: begin
            if (step_count == '0) fin_res.status = hvd_pkg::ST_NOSTEPS;
            else begin
              fin_en  = 1'b0;
              st_next = hvd_pkg::S_RD;
            end
          end
          hvd_pkg::FN_TRACE: begin
            if (step_count == '0) fin_res.status = hvd_pkg::ST_NOSTEPS;
            else if (step_open) fin_res.status = hvd_pkg::ST_BAD;
            else begin
              fin_en  = 1'b0;
              st_next = trace_active ? hvd_pkg::S_TBRD : hvd_pkg::S_RD;
            end
          end
          hvd_pkg::FN_CLEAR: ;
          default: ;
        endcase
      end
      hvd_pkg::S_CLR: begin
        pm_we    = 1'b1;
        pm_wdata = MET_MIN;
        bp_we    = 1'b1;
        if (sidx == SW'(NUM_STATES - 1)) st_next = hvd_pkg::S_RD;
      end
      hvd_pkg::S_RD: st_next = hvd_pkg::S_ADD;
      hvd_pkg::S_ADD: begin
        st_next = (mode == hvd_pkg::LM_FIRST) ? hvd_pkg::S_FIN : hvd_pkg::S_CMP;
      end
      hvd_pkg::S_CMP: begin
        pm_we = mode == hvd_pkg::LM_STOP;
        if (!s_last) st_next = hvd_pkg::S_RD;
        else begin
          unique case (mode)
            hvd_pkg::LM_STOP: begin
              st_next = hvd_pkg::S_IDLE;
              fin_en  = 1'b1;
              fin_res.best_state = 3'(best_now);
            end
            hvd_pkg::LM_BEST: st_next = hvd_pkg::S_TBRD;
            default:          st_next = hvd_pkg::S_FIN;
          endcase
        end
      end
      hvd_pkg::S_FIN: begin
        pm_we    = 1'b1;
        pm_waddr = {wbank, row_s};
        pm_wdata = met_add(bm, req.log_value);
        bp_we    = 1'b1;
        bp_waddr = {cur, row_s};
        bp_wdata = best;
        st_next  = hvd_pkg::S_IDLE;
        fin_en   = 1'b1;
        fin_res.best_state = req.row_index;
      end
      hvd_pkg::S_TBRD: begin
        vec_raddr = traced;
        st_next   = hvd_pkg::S_TBOUT;
      end
      hvd_pkg::S_TBOUT: begin
        st_next = hvd_pkg::S_IDLE;
        fin_en  = 1'b1;
        fin_res.state_label = label_rdata;
        fin_res.best_state  = 3'(traced);
        fin_res.trace_done  = cursor == '0;
      end
      default: st_next = hvd_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count   <= '0;
      step_open    <= 1'b0;
      trace_active <= 1'b0;
      cursor       <= '0;
      traced       <= '0;
      done         <= 1'b0;
    end else begin
      done <= fin_en;
      if (st == hvd_pkg::S_DISP) begin
        unique case (req.func)
          hvd_pkg::FN_EMIT: begin
            if (!row_bad_em && (step_open || 32'(step_count) < MAX_STEPS)) begin
              trace_active <= 1'b0;
              if (!step_open) begin
                step_count <= step_count + SCW'(1);
                step_open  <= 1'b1;
              end
            end
          end
          hvd_pkg::FN_STOP: begin
            if (step_count != '0) begin
              step_open    <= 1'b0;
              trace_active <= 1'b0;
            end
          end
          hvd_pkg::FN_TRACE: begin
            if (step_count != '0 && !step_open && !trace_active) cursor <= last_step;
          end
          hvd_pkg::FN_CLEAR: begin
            step_count   <= '0;
            step_open    <= 1'b0;
            trace_active <= 1'b0;
            cursor       <= '0;
            traced       <= '0;
          end
          default: ;
        endcase
      end
      if (st == hvd_pkg::S_CMP && s_last && mode == hvd_pkg::LM_BEST) begin
        traced       <= best_now;
        trace_active <= 1'b1;
      end
      if (st == hvd_pkg::S_FIN && req.step_last) step_open <= 1'b0;
      if (st == hvd_pkg::S_TBOUT) begin
        if (cursor == '0) trace_active <= 1'b0;
        else begin
          traced <= bp_rdata;
          cursor <= cursor - CW'(1);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (st == hvd_pkg::S_IDLE && start) req <= item;
    if (fin_en) result <= fin_res;
    unique case (st)
      hvd_pkg::S_DISP: begin
        sidx <= '0;
        if (req.func == hvd_pkg::FN_EMIT) begin
          // open a new step or continue the one in flight
          if (step_open) begin
            cur   <= last_step;
            wbank <= last_step[0];
            lbank <= ~last_step[0];
            mode  <= (last_step == '0) ? hvd_pkg::LM_FIRST : hvd_pkg::LM_EMIT;
          end else begin
            cur   <= CW'(step_count);
            wbank <= step_count[0];
            lbank <= ~step_count[0];
            mode  <= (step_count == '0) ? hvd_pkg::LM_FIRST : hvd_pkg::LM_EMIT;
          end
        end else begin
          wbank <= last_step[0];
          lbank <= last_step[0];
          mode  <= (req.func == hvd_pkg::FN_STOP) ? hvd_pkg::LM_STOP : hvd_pkg::LM_BEST;
        end
      end
      hvd_pkg::S_CLR: sidx <= (sidx == SW'(NUM_STATES - 1)) ? '0 : sidx + SW'(1);
      hvd_pkg::S_ADD: begin
        unique case (mode)
          hvd_pkg::LM_FIRST: begin
            bm   <= met_add('0, start_rdata);
            best <= '0;
          end
          hvd_pkg::LM_EMIT: cand <= met_add(pm_rdata, trans_rdata);
          hvd_pkg::LM_STOP: cand <= met_add(pm_rdata, final_rdata);
          default:          cand <= pm_rdata;
        endcase
      end
      hvd_pkg::S_CMP: begin
        if (upd) bm <= cand;
        best <= best_now;
        sidx <= sidx + SW'(1);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
